### rtl/core/dssm_pkg.sv
// shared types, constants and coefficient table for the discrete state model
package dssm_pkg;

   // fixed dimensions
   localparam int NUM_INPUTS    = 12;
   localparam int NUM_STATES    = 3;
   localparam int NUM_MACS      = 54;
   localparam int IN_W          = 16;
   localparam int STATE_W       = 32;
   localparam int COEF_W        = 32;
   localparam int ACC_W         = 64;
   localparam int STEP_W        = 6;
   localparam int IN_FRAC_BITS  = 8;
   localparam int SRC_FRAC_BITS = 24;

   typedef logic signed [IN_W-1:0]    in_word_type;
   typedef logic signed [STATE_W-1:0] state_word_type;
   typedef logic signed [COEF_W-1:0]  coef_word_type;

   // one multiply-accumulate command
   typedef struct packed {
      logic              mac;
      logic [STEP_W-1:0] coef_idx;
      logic              use_state;
      logic [3:0]        opnd_idx;
      logic              first;
      logic              ad_first;
      logic              last;
      logic              to_out;
      logic [1:0]        row;
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic    load;
      logic    commit;
      cmd_type cmd;
   } ctl_type;

   // coefficients with 24 fractional bits, in issue order:
   // C rows, then for each state row the Bd row followed by the Ad row
   localparam coef_word_type COEF_ROM [NUM_MACS] = '{
      -32'sd236837650, -32'sd43114470, 32'sd15714962,
      -32'sd22102337,  -32'sd5612147,  32'sd2113720,
      -32'sd13090245,  -32'sd2580090,  32'sd875847,
      // row 0
      32'sd6492056, 32'sd8623508, 32'sd567709, 32'sd5037019,
      -32'sd6779476, 32'sd5733715, -32'sd5683539, 32'sd3434432,
      -32'sd5066792, -32'sd6923542, -32'sd10102584, -32'sd364042,
      32'sd16763365, 32'sd28386, 32'sd16251,
      // row 1
      -32'sd387987888, -32'sd584872207, -32'sd24710118, -32'sd434771079,
      32'sd499708687, -32'sd446869685, 32'sd437924633, -32'sd212704268,
      32'sd389306501, 32'sd371824950, 32'sd630316035, 32'sd160383,
      32'sd652865, 32'sd15068673, -32'sd1127259,
      // row 2
      -32'sd966613156, -32'sd1476356843, -32'sd60566616, -32'sd1118898589,
      32'sd1271831846, -32'sd1142439738, 32'sd1117071293, -32'sd531686740,
      32'sd994222205, 32'sd915030651, 32'sd1576199165, -32'sd3935795,
      32'sd1670318, -32'sd4247654, 32'sd13925739
   };

endpackage

### rtl/core/discrete_state_space_model.sv
// Once a transaction is accepted, the single shared multiplier does its 54
// multiply-accumulates in turn, and the datapath then commits the result.
// Transactions do not overlap: the next is accepted only after that commit.
// A held result stalls the next commit but not the next input acceptance.
// Reset (synchronous, active high) clears the state vector and all handshakes.
module discrete_state_space_model #(
   parameter int STATE_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_u0,
   input  logic signed [15:0]   req_u1,
   input  logic signed [15:0]   req_u2,
   input  logic signed [15:0]   req_u3,
   input  logic signed [15:0]   req_u4,
   input  logic signed [15:0]   req_u5,
   input  logic signed [15:0]   req_u6,
   input  logic signed [15:0]   req_u7,
   input  logic signed [15:0]   req_u8,
   input  logic signed [15:0]   req_u9,
   input  logic signed [15:0]   req_u10,
   input  logic signed [15:0]   req_u11,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_y0,
   output logic signed [31:0]   rsp_y1,
   output logic signed [31:0]   rsp_y2
);

   dssm_pkg::ctl_type        ctl;
   dssm_pkg::in_word_type    u_vec [dssm_pkg::NUM_INPUTS];
   dssm_pkg::state_word_type y_vec [dssm_pkg::NUM_STATES];

   // gather input channels
   assign u_vec[0]  = req_u0;
   assign u_vec[1]  = req_u1;
   assign u_vec[2]  = req_u2;
   assign u_vec[3]  = req_u3;
   assign u_vec[4]  = req_u4;
   assign u_vec[5]  = req_u5;
   assign u_vec[6]  = req_u6;
   assign u_vec[7]  = req_u7;
   assign u_vec[8]  = req_u8;
   assign u_vec[9]  = req_u9;
   assign u_vec[10] = req_u10;
   assign u_vec[11] = req_u11;

   dssm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   dssm_datapath #(
      .STATE_FRAC_BITS (STATE_FRAC_BITS),
      .COEF_FRAC_BITS  (COEF_FRAC_BITS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .req_u (u_vec),
      .rsp_y (y_vec)
   );

   // scatter output channels
   assign rsp_y0 = y_vec[0];
   assign rsp_y1 = y_vec[1];
   assign rsp_y2 = y_vec[2];

endmodule

### rtl/core/dssm_datapath.sv
// shared multiply-accumulate datapath with state, input and result registers
module dssm_datapath #(
   parameter int STATE_FRAC_BITS = 16,
   parameter int COEF_FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dssm_pkg::ctl_type        ctl,
   input  dssm_pkg::in_word_type    req_u [dssm_pkg::NUM_INPUTS],
   output dssm_pkg::state_word_type rsp_y [dssm_pkg::NUM_STATES]
);

   localparam int COEF_SHIFT  = dssm_pkg::SRC_FRAC_BITS - COEF_FRAC_BITS;
   localparam longint COEF_HALF = (longint'(1) << COEF_SHIFT) >> 1;
   localparam int ALIGN_SHIFT = STATE_FRAC_BITS - dssm_pkg::IN_FRAC_BITS;
   localparam logic signed [dssm_pkg::ACC_W-1:0] BU_LIMIT =
      64'sd1 <<< (69 - STATE_FRAC_BITS);
   localparam logic signed [dssm_pkg::ACC_W-1:0] ROUND_HALF =
      64'sd1 <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [dssm_pkg::ACC_W-1:0] SAT_MAX = 64'sd2147483647;
   localparam logic signed [dssm_pkg::ACC_W-1:0] SAT_MIN = -64'sd2147483648;

   dssm_pkg::in_word_type    u_ff     [dssm_pkg::NUM_INPUTS];
   dssm_pkg::state_word_type state_ff [dssm_pkg::NUM_STATES];
   dssm_pkg::state_word_type next_ff  [dssm_pkg::NUM_STATES];
   dssm_pkg::state_word_type yw_ff    [dssm_pkg::NUM_STATES];
   dssm_pkg::state_word_type y_ff     [dssm_pkg::NUM_STATES];

   dssm_pkg::cmd_type cmd1_ff;
   dssm_pkg::cmd_type cmd2_ff;

   logic signed [dssm_pkg::ACC_W-1:0] prod_ff;
   logic signed [dssm_pkg::ACC_W-1:0] prod_in;
   logic signed [dssm_pkg::ACC_W-1:0] acc_ff;
   logic signed [dssm_pkg::ACC_W-1:0] acc_in;

   dssm_pkg::coef_word_type        q24;
   logic signed [dssm_pkg::COEF_W:0] coef_sum;
   dssm_pkg::coef_word_type        coef_val;
   dssm_pkg::state_word_type       opnd;

   logic signed [dssm_pkg::ACC_W-1:0] bu_clamped;
   logic signed [dssm_pkg::ACC_W-1:0] bu_scaled;
   logic signed [dssm_pkg::ACC_W-1:0] base;

   logic signed [dssm_pkg::ACC_W-1:0] res_sum;
   logic signed [dssm_pkg::ACC_W-1:0] res_shift;
   dssm_pkg::state_word_type          res_sat;

   // coefficient lookup rounded half up to the working precision
   always_comb begin
      q24      = dssm_pkg::COEF_ROM[ctl.cmd.coef_idx];
      coef_sum = 33'(q24) + 33'(COEF_HALF);
      coef_val = 32'(coef_sum >>> COEF_SHIFT);
   end

   // operand select: state element or input channel
   always_comb begin
      if (ctl.cmd.use_state) begin
         opnd = state_ff[ctl.cmd.opnd_idx[1:0]];
      end else begin
         opnd = 32'(u_ff[ctl.cmd.opnd_idx]);
      end
      prod_in = 64'(coef_val) * 64'(opnd);
   end

   // input sum clamp and alignment to state precision, then accumulate
   always_comb begin
      if (acc_ff > BU_LIMIT) begin
         bu_clamped = BU_LIMIT;
      end else if (acc_ff < -BU_LIMIT) begin
         bu_clamped = -BU_LIMIT;
      end else begin
         bu_clamped = acc_ff;
      end
      bu_scaled = bu_clamped <<< ALIGN_SHIFT;
      if (cmd1_ff.first) begin
         base = '0;
      end else if (cmd1_ff.ad_first) begin
         base = bu_scaled;
      end else begin
         base = acc_ff;
      end
      acc_in = base + prod_ff;
   end

   // round half up and saturate the finished sum
   always_comb begin
      res_sum   = acc_ff + ROUND_HALF;
      res_shift = res_sum >>> COEF_FRAC_BITS;
      if (res_shift > SAT_MAX) begin
         res_sat = 32'(SAT_MAX);
      end else if (res_shift < SAT_MIN) begin
         res_sat = 32'(SAT_MIN);
      end else begin
         res_sat = 32'(res_shift);
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd1_ff <= '0;
         cmd2_ff <= '0;
      end else begin
         cmd1_ff <= ctl.cmd;
         cmd2_ff <= cmd1_ff;
      end
   end

   // multiplier and accumulator registers
   always_ff @(posedge clock) begin
      if (ctl.cmd.mac) begin
         prod_ff <= prod_in;
      end
      if (cmd1_ff.mac) begin
         acc_ff <= acc_in;
      end
   end

   // input capture, result write-back and output registers
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         u_ff <= req_u;
      end
      if (cmd2_ff.mac && cmd2_ff.last) begin
         if (cmd2_ff.to_out) begin
            yw_ff[cmd2_ff.row] <= res_sat;
         end else begin
            next_ff[cmd2_ff.row] <= res_sat;
         end
      end
      if (ctl.commit) begin
         y_ff <= yw_ff;
      end
   end

   // state vector, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dssm_pkg::NUM_STATES; i++) begin
            state_ff[i] <= '0;
         end
      end else if (ctl.commit) begin
         state_ff <= next_ff;
      end
   end

   assign rsp_y = y_ff;

endmodule

### rtl/core/dssm_controller.sv
// sequencer that steps the shared multiply-accumulate through one transaction
module dssm_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dssm_pkg::ctl_type ctl
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   localparam logic [1:0] PH_C  = 2'd0;
   localparam logic [1:0] PH_BU = 2'd1;
   localparam logic [1:0] PH_AD = 2'd2;

   localparam logic [3:0] LAST_STATE_COL = 4'(dssm_pkg::NUM_STATES - 1);
   localparam logic [3:0] LAST_INPUT_COL = 4'(dssm_pkg::NUM_INPUTS - 1);
   localparam logic [1:0] LAST_ROW       = 2'(dssm_pkg::NUM_STATES - 1);

   logic [1:0]                  state_ff, state_in;
   logic [1:0]                  phase_ff, phase_in;
   logic [dssm_pkg::STEP_W-1:0] step_ff, step_in;
   logic [3:0]                  col_ff, col_in;
   logic [1:0]                  row_ff, row_in;
   logic                        drain_ff, drain_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               phase_in = PH_C;
               step_in  = '0;
               col_in   = '0;
               row_in   = '0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            case (phase_ff)
               PH_C: begin
                  if (col_ff == LAST_STATE_COL) begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        row_in   = '0;
                        phase_in = PH_BU;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               PH_BU: begin
                  if (col_ff == LAST_INPUT_COL) begin
                     col_in   = '0;
                     phase_in = PH_AD;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               PH_AD: begin
                  if (col_ff == LAST_STATE_COL) begin
                     col_in = '0;
                     if (row_ff == LAST_ROW) begin
                        row_in   = '0;
                        state_in = ST_DRAIN;
                        drain_in = 1'b0;
                     end else begin
                        row_in   = row_ff + 1'b1;
                        phase_in = PH_BU;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_C;
               end
            endcase
         end
         ST_DRAIN: begin
            drain_in = !drain_ff;
            if (drain_ff) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_C;
         step_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // commands to the datapath
   always_comb begin
      ctl.load          = (state_ff == ST_IDLE) && req_valid;
      ctl.commit        = (state_ff == ST_COMMIT) && out_free;
      ctl.cmd.mac       = (state_ff == ST_RUN);
      ctl.cmd.coef_idx  = step_ff;
      ctl.cmd.use_state = (phase_ff != PH_BU);
      ctl.cmd.opnd_idx  = col_ff;
      ctl.cmd.first     = (phase_ff != PH_AD) && (col_ff == '0);
      ctl.cmd.ad_first  = (phase_ff == PH_AD) && (col_ff == '0);
      ctl.cmd.last      = (phase_ff != PH_BU) && (col_ff == LAST_STATE_COL);
      ctl.cmd.to_out    = (phase_ff == PH_C);
      ctl.cmd.row       = row_ff;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // the last command of a transaction uses the last coefficient
   a_step_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && state_in == ST_DRAIN)
         |-> step_ff == dssm_pkg::STEP_W'(dssm_pkg::NUM_MACS - 1))
      else $error("sequence ended at wrong step");

   // a new result only follows a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result raised without commit");

   // commit waits while the output register is held
   a_commit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && rsp_valid_ff && rsp_stall) |=> state_ff == ST_COMMIT)
      else $error("commit over a held result");

   // counters stay within the table
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (row_ff <= LAST_ROW && col_ff <= LAST_INPUT_COL))
      else $error("row or column out of range");
`endif

endmodule
